FILE: src/cda_pkg.sv
// Package for the cascaded distance averager: payload structs, ring codes,
// default ring depths and reset constants. No dependencies.
`default_nettype none

package cda_pkg;

    localparam int DATA_W = 16;
    localparam int TS_W   = 32;

    localparam int RECENT_DEPTH_DEF  = 60;
    localparam int MINUTE_DEPTH_DEF  = 15;
    localparam int QUARTER_DEPTH_DEF = 4;
    localparam int HOUR_DEPTH_DEF    = 24;

    localparam logic [TS_W-1:0] INTERVAL_RESET = 32'd60000;

    // Ring select codes; each ring owns one region of the shared RAM.
    typedef enum logic [1:0] {
        RING_RECENT  = 2'd0,
        RING_MINUTE  = 2'd1,
        RING_QUARTER = 2'd2,
        RING_HOUR    = 2'd3
    } t_ring;

    typedef struct packed {
        logic              read_ok;
        logic [DATA_W-1:0] distance_cm;
        logic [TS_W-1:0]   timestamp_ms;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] distance_out;
        logic [DATA_W-1:0] recent_avg;
        logic [DATA_W-1:0] quarter_avg;
        logic [DATA_W-1:0] hour_avg;
        logic [DATA_W-1:0] day_avg;
    } t_out;

endpackage

`default_nettype wire

FILE: src/cda_ram.sv
// Generic single-port-write, registered-read RAM for the averager rings.
// No dependencies.
`default_nettype none

module cda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/cda_div.sv
// Restoring divider, one quotient bit per cycle, for the ring averages.
// Zero divisor gives zero. Depends on nothing outside this file.
`default_nettype none

module cda_div #(
    parameter int DW = 22,
    parameter int VW = 6,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic      [QW-1:0] o_quot
);

    localparam int SW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic          r_zero;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   w_trial;
    logic          w_ge;
    logic [VW:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == SW'(DW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            r_quo  <= {r_quo[DW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_done = r_done;
    // a mean never exceeds its largest entry, so the low bits hold it
    assign o_quot = r_zero ? '0 : r_quo[QW-1:0];

endmodule

`default_nettype wire

FILE: src/cascaded_distance_averager.sv
// Cascaded distance averager, top level. Uses cda_pkg, cda_ram, cda_div.
// Transactions are handled one at a time on the shared divider; a failed read
//   skips the ring read and write, and each ring level reached by the cascade
//   adds a ring update and a division.
// Reset: synchronous, active low; fill flags make unwritten slots read as zero.
`default_nettype none

module cascaded_distance_averager
    import cda_pkg::*;
#(
    parameter int RECENT_DEPTH  = RECENT_DEPTH_DEF,
    parameter int MINUTE_DEPTH  = MINUTE_DEPTH_DEF,
    parameter int QUARTER_DEPTH = QUARTER_DEPTH_DEF,
    parameter int HOUR_DEPTH    = HOUR_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire t_in             i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output t_out                 o_out,
    input  wire logic            i_cfg_we,
    input  wire logic [TS_W-1:0] i_cfg_wdata
);

    // ---------------------------------------------------------------------
    // Derived sizes. All four rings share one RAM, laid out back to back.
    // Each ring keeps a running sum and a count of its nonzero entries, so an
    // average is a single division instead of a walk over the ring.
    // ---------------------------------------------------------------------
    localparam int MAX_RM = (RECENT_DEPTH > MINUTE_DEPTH) ? RECENT_DEPTH : MINUTE_DEPTH;
    localparam int MAX_QH = (QUARTER_DEPTH > HOUR_DEPTH) ? QUARTER_DEPTH : HOUR_DEPTH;
    localparam int MAX_D  = (MAX_RM > MAX_QH) ? MAX_RM : MAX_QH;
    localparam int TOT_D  = RECENT_DEPTH + MINUTE_DEPTH + QUARTER_DEPTH + HOUR_DEPTH;
    localparam int AW     = $clog2(TOT_D);
    localparam int PW     = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam int CNT_W  = $clog2(MAX_D + 1);
    localparam int SUM_W  = DATA_W + CNT_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD     = 8'b0000_0010,  // RAM read of the slot about to be overwritten
        ST_WR     = 8'b0000_0100,  // write back, update sum and count
        ST_CSTART = 8'b0000_1000,  // start mean of the ring just written
        ST_CWAIT  = 8'b0001_0000,  // wait for it, then move to the next ring
        ST_AVG    = 8'b0010_0000,  // start mean of a ring for the result
        ST_AWAIT  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000   // hand result to the output register
    } t_state;

    t_state r_state, n_state;

    // configuration and timing
    logic [TS_W-1:0]   r_interval;
    logic [TS_W-1:0]   r_last;
    logic [TS_W-1:0]   w_elapsed;

    // per-item working registers
    logic              r_cons;   // this item consolidates into the minute ring
    logic [DATA_W-1:0] r_dist;
    logic [DATA_W-1:0] r_wdata;
    t_ring             r_ring;

    // per-ring bookkeeping, indexed by ring code
    logic [PW-1:0]     r_pos  [4];
    logic              r_full [4];
    logic [SUM_W-1:0]  r_sum  [4];
    logic [CNT_W-1:0]  r_cnt  [4];
    logic [DATA_W-1:0] r_avg  [4];

    // output register
    t_out              r_out;
    logic              r_out_valid;

    // RAM and divider
    logic [AW-1:0]     w_base;
    logic [AW-1:0]     w_addr;
    logic [PW-1:0]     w_last_pos;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_old;
    logic              w_we;
    logic              w_wrap;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic              w_in_acc;
    logic              w_out_free;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_elapsed  = i_in.timestamp_ms - r_last;

    always_comb begin
        case (r_ring)
            RING_RECENT: begin
                w_base     = '0;
                w_last_pos = PW'(RECENT_DEPTH - 1);
            end
            RING_MINUTE: begin
                w_base     = AW'(RECENT_DEPTH);
                w_last_pos = PW'(MINUTE_DEPTH - 1);
            end
            RING_QUARTER: begin
                w_base     = AW'(RECENT_DEPTH + MINUTE_DEPTH);
                w_last_pos = PW'(QUARTER_DEPTH - 1);
            end
            RING_HOUR: begin
                w_base     = AW'(RECENT_DEPTH + MINUTE_DEPTH + QUARTER_DEPTH);
                w_last_pos = PW'(HOUR_DEPTH - 1);
            end
            default: begin
                w_base     = '0;
                w_last_pos = '0;
            end
        endcase
    end

    assign w_addr = w_base + AW'(r_pos[r_ring]);
    // slot never written since reset reads as zero: writes fill in order
    assign w_old  = r_full[r_ring] ? w_rdata : '0;
    assign w_we   = (r_state == ST_WR);
    assign w_wrap = (r_pos[r_ring] == w_last_pos);

    assign w_div_start = (r_state == ST_CSTART) || (r_state == ST_AVG);

    cda_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TOT_D),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (r_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    cda_div #(
        .DW (SUM_W),
        .VW (CNT_W),
        .QW (DATA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum[r_ring]),
        .i_divisor  (r_cnt[r_ring]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in.read_ok ? ST_RD : ST_AVG;
                end
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                // cascade: recent ring on an elapsed interval, the minute and
                // quarter rings each time they wrap; the hour ring ends it
                case (r_ring)
                    RING_RECENT:  n_state = r_cons ? ST_CSTART : ST_AVG;
                    RING_MINUTE:  n_state = w_wrap ? ST_CSTART : ST_AVG;
                    RING_QUARTER: n_state = w_wrap ? ST_CSTART : ST_AVG;
                    default:      n_state = ST_AVG;
                endcase
            end
            ST_CSTART: n_state = ST_CWAIT;
            ST_CWAIT: begin
                if (w_div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_AVG: n_state = ST_AWAIT;
            ST_AWAIT: begin
                if (w_div_done) begin
                    n_state = (r_ring == RING_HOUR) ? ST_DONE : ST_AVG;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interval  <= INTERVAL_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_pos[k]  <= '0;
                r_full[k] <= 1'b0;
                r_sum[k]  <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (w_in_acc && i_in.read_ok && (w_elapsed >= r_interval)) begin
                r_last <= i_in.timestamp_ms;
            end
            if (r_state == ST_WR) begin
                r_sum[r_ring] <= r_sum[r_ring] + SUM_W'(r_wdata) - SUM_W'(w_old);
                r_cnt[r_ring] <= r_cnt[r_ring] + CNT_W'(r_wdata != '0)
                                 - CNT_W'(w_old != '0);
                if (w_wrap) begin
                    r_pos[r_ring]  <= '0;
                    r_full[r_ring] <= 1'b1;
                end else begin
                    r_pos[r_ring] <= r_pos[r_ring] + PW'(1);
                end
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cons  <= i_in.read_ok && (w_elapsed >= r_interval);
            r_dist  <= i_in.read_ok ? i_in.distance_cm : '0;
            r_wdata <= i_in.distance_cm;
            r_ring  <= RING_RECENT;
        end
        if ((r_state == ST_WR) && (n_state == ST_AVG)) begin
            r_ring <= RING_RECENT;
        end
        if ((r_state == ST_CWAIT) && w_div_done) begin
            r_wdata <= w_quot;
            case (r_ring)
                RING_RECENT:  r_ring <= RING_MINUTE;
                RING_MINUTE:  r_ring <= RING_QUARTER;
                default:      r_ring <= RING_HOUR;
            endcase
        end
        if ((r_state == ST_AWAIT) && w_div_done) begin
            r_avg[r_ring] <= w_quot;
            case (r_ring)
                RING_RECENT:  r_ring <= RING_MINUTE;
                RING_MINUTE:  r_ring <= RING_QUARTER;
                default:      r_ring <= RING_HOUR;
            endcase
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out.distance_out <= r_dist;
            r_out.recent_avg   <= r_avg[RING_RECENT];
            r_out.quarter_avg  <= r_avg[RING_MINUTE];
            r_out.hour_avg     <= r_avg[RING_QUARTER];
            r_out.day_avg      <= r_avg[RING_HOUR];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a RAM write always follows the read of the same slot
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ($past(r_state) == ST_RD))
        else $error("ring write without preceding read");

    // nonzero count of the recent and hour rings can never exceed the ring's depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[RING_RECENT] <= CNT_W'(RECENT_DEPTH)) &&
        (r_cnt[RING_HOUR] <= CNT_W'(HOUR_DEPTH)))
        else $error("nonzero count above ring depth");

    // divider results only arrive while the sequencer waits for them
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == ST_CWAIT) || (r_state == ST_AWAIT)))
        else $error("divider finished outside a wait state");

    // an accepted transaction is worked on, not immediately followed by another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("second transaction accepted back to back");

endmodule

`default_nettype wire
